@@ rtl/vpw_pkg.sv @@
// Shared types and constants of the vertex-to-window projection block.
package vpw_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned VP_W    = 16;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned REG_W   = 2;

  // Item operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_VP_LEFT   = 2'd0;
  localparam logic [REG_W-1:0] REG_VP_BOTTOM = 2'd1;
  localparam logic [REG_W-1:0] REG_VP_WIDTH  = 2'd2;
  localparam logic [REG_W-1:0] REG_VP_HEIGHT = 2'd3;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          coeff_index;
    logic signed [COEF_W-1:0]  coeff_value;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] window_x;
    logic signed [COORD_W-1:0] window_y;
    logic signed [COORD_W-1:0] window_z;
    logic                      projected_ok;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] index;
    logic [VP_W-1:0]  value;
  } cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MAP_LO,
    ST_MAP_HI,
    ST_MAP_ADD,
    ST_DEPTH,
    ST_DONE
  } seq_state_e;

endpackage

@@ rtl/vpw_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
interface vpw_in_if import vpw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vpw_out_if import vpw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vpw_cfg_if import vpw_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/vpw_coeff_mem.sv @@
// Coefficient store: 32 words, one write port, one registered read port.
module vpw_coeff_mem import vpw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IDX_W-1:0]         waddr_i,
  input  logic signed [COEF_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]         raddr_i,
  output logic signed [COEF_W-1:0] rdata_o
);

  logic signed [COEF_W-1:0] mem [2**IDX_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/vpw_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
module vpw_mul import vpw_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

@@ rtl/vpw_divider.sv @@
// Restoring divider: (n << FRAC) / d, one quotient bit per cycle, saturated.
module vpw_divider import vpw_pkg::*; #(
  parameter int unsigned W    = 32,
  parameter int unsigned FRAC = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic                done_o,
  output logic signed [W-1:0] quot_o
);

  localparam int unsigned DW = W + FRAC;
  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [DW-1:0] POS_LIM = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DW-1:0] NEG_LIM = {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [CW-1:0] LAST    = CW'(DW - 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dq_q;
  logic [W-1:0]  rem_q, ud_q;
  logic [W-1:0]  un, ud;
  logic [W:0]    rs, diff;
  logic          ge;

  assign un   = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign ud   = den_i[W-1] ? W'(-den_i) : W'(den_i);
  assign rs   = {rem_q, dq_q[DW-1]};
  assign diff = rs - {1'b0, ud_q};
  assign ge   = rs >= {1'b0, ud_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {un, {FRAC{1'b0}}};
      rem_q <= '0;
      ud_q  <= ud;
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : rs[W-1:0];
      dq_q  <= {dq_q[DW-2:0], ge};
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (dq_q > NEG_LIM) ? W'(-NEG_LIM) : W'(-dq_q);
    end else begin
      quot_o = (dq_q > POS_LIM) ? POS_LIM[W-1:0] : dq_q[W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

@@ rtl/vertex_project_to_window.sv @@
// Top level: projects an object-space point into viewport window coordinates.
//
// Channels: item_i carries input beats. A load beat (operation 0) writes one
// signed Q16.16 coefficient into the 32-word store (entries 0-15 model matrix,
// 16-31 projection matrix, column-major) and produces no result. A project
// beat (operation 1) carries x, y and z and produces one beat on result_o.
// cfg_i writes the four 16-bit viewport registers; it is always ready and
// should only be used while no item is in flight.
//
// Sequence: a load beat is written when accepted and leaves the sequencer idle.
// A project beat runs a sequencer around one shared 32x32 multiplier: each of
// the 32 matrix terms runs through a coefficient read, the low and high partial
// products and an accumulate. A check state then tests w, three restoring
// divisions by w follow, and then viewport mapping, depth and the hand-off to
// the output register. When w is zero, division, mapping and depth are skipped.
//
// Reset clears the sequencer, the viewport registers and the result valid flag;
// the coefficient store is not cleared and must be loaded before use. A held
// result does not block the next beat; the block only stalls at the end of
// that next item if the result is still held.
module vertex_project_to_window import vpw_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  vpw_cfg_if.sink   cfg_i,
  vpw_in_if.sink    item_i,
  vpw_out_if.source result_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned VW = (W > 32) ? W : 32;

  localparam logic signed [63:0] WMAX     = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN     = -(64'sd1 <<< (W - 1));
  localparam logic [63:0]        Q_LIM    = 64'd1 << (28 + F);
  localparam logic [63:0]        TERM_LIM = 64'd1 << 60;
  localparam logic signed [49:0] ONE_50   = 50'sd1 <<< F;
  localparam logic signed [49:0] MAP_LIM  = 50'sd1 <<< 47;
  localparam logic signed [VW-1:0] ONE_V  = VW'(64'sd1 <<< F);

  function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
    return r[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Viewport registers.
  logic [VP_W-1:0] vp_left_q, vp_bottom_q, vp_width_q, vp_height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_left_q   <= '0;
      vp_bottom_q <= '0;
      vp_width_q  <= '0;
      vp_height_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_VP_LEFT:   vp_left_q   <= cfg_i.data.value;
        REG_VP_BOTTOM: vp_bottom_q <= cfg_i.data.value;
        REG_VP_WIDTH:  vp_width_q  <= cfg_i.data.value;
        REG_VP_HEIGHT: vp_height_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  seq_state_e state_q, state_d;
  logic       stage_q;
  logic [1:0] row_q, col_q, k_q;

  logic signed [VW-1:0] src_q [4];
  logic signed [W-1:0]  dst_q [4];
  logic signed [W-1:0]  ndc_q [3];
  logic signed [63:0]   acc_q;
  logic [63:0]          p_q;
  logic signed [31:0]   win_q [3];
  logic                 ok_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic accept, load_we, out_free;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign load_we      = accept && (item_i.data.operation == OP_LOAD);
  assign out_free     = !out_valid_q || result_o.ready;

  // Coefficient store, addressed as stage*16 + column*4 + row.
  logic signed [COEF_W-1:0] coef;

  vpw_coeff_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (item_i.data.coeff_index),
    .wdata_i (item_i.data.coeff_value),
    .raddr_i ({stage_q, col_q, row_q}),
    .rdata_o (coef)
  );

  // Term operands: magnitudes of the coefficient and of the vector element.
  logic [31:0]          ua;
  logic signed [VW-1:0] bsrc;
  logic [VW-1:0]        ub;
  logic [63:0]          ub64;
  logic                 term_neg;

  assign ua       = coef[31] ? 32'(-coef) : 32'(coef);
  assign bsrc     = src_q[col_q];
  assign ub       = bsrc[VW-1] ? VW'(-bsrc) : VW'(bsrc);
  assign ub64     = 64'(ub);
  assign term_neg = coef[31] ^ bsrc[VW-1];

  // Viewport operands for the element selected by k.
  logic signed [49:0] vsum, vcl;
  logic [47:0]        mv;
  logic [VP_W-1:0]    vp_size, vp_org;

  assign vsum    = 50'(ndc_q[k_q]) + ONE_50;
  assign vcl     = (vsum > MAP_LIM) ? MAP_LIM : ((vsum < -MAP_LIM) ? -MAP_LIM : vsum);
  assign mv      = vcl[49] ? 48'(-vcl) : 48'(vcl);
  assign vp_size = (k_q == 2'd0) ? vp_width_q : vp_height_q;
  assign vp_org  = (k_q == 2'd0) ? vp_left_q : vp_bottom_q;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = ua;
    mul_b = ub64[31:0];
    unique case (state_q)
      ST_MUL_HI: mul_b = ub64[63:32];
      ST_MAP_LO: begin
        mul_a = 32'(vp_size);
        mul_b = mv[31:0];
      end
      ST_MAP_HI: begin
        mul_a = 32'(vp_size);
        mul_b = 32'(mv[47:32]);
      end
      default: ;
    endcase
  end

  vpw_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Term combine: drop the fraction bits, cap the magnitude, apply the sign.
  logic [63:0]        t_raw, t_cap;
  logic signed [63:0] term, acc_sum;
  logic signed [W-1:0] row_sat;

  assign t_raw   = (prod << (32 - F)) + (p_q >> F);
  assign t_cap   = ((prod >= Q_LIM) || (t_raw > TERM_LIM)) ? TERM_LIM : t_raw;
  assign term    = term_neg ? -$signed(t_cap) : $signed(t_cap);
  assign acc_sum = acc_q + term;
  assign row_sat = sat_w(acc_sum);

  // Viewport add: halve the scaled value, add the origin, saturate.
  logic [63:0]        m_mag;
  logic signed [65:0] map_sum;
  logic signed [31:0] map_res;

  assign m_mag   = (p_q + (prod << 32)) >> 1;
  assign map_sum = (vcl[49] ? -66'(m_mag) : 66'(m_mag)) + (66'(vp_org) <<< F);
  assign map_res = sat32(map_sum);

  // Depth: (1 + z/w) / 2 truncated toward zero.
  logic signed [49:0] dsum;
  logic [49:0]        dmag;
  logic signed [31:0] depth_res;

  assign dsum      = 50'(ndc_q[2]) + ONE_50;
  assign dmag      = dsum[49] ? 50'(-dsum) : 50'(dsum);
  assign depth_res = sat32(dsum[49] ? -66'(dmag >> 1) : 66'(dmag >> 1));

  // Divider for the perspective divide.
  logic                div_start, div_done;
  logic signed [W-1:0] div_quot;

  vpw_divider #(.W(W), .FRAC(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dst_q[k_q]),
    .den_i   (dst_q[3]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.data.operation == OP_PROJECT)) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ACCUM;
      ST_ACCUM: begin
        if (stage_q && (row_q == 2'd3) && (col_q == 2'd3)) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_CHECK:  state_d = (dst_q[3] == '0) ? ST_DONE : ST_DIV_GO;
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (k_q == 2'd2) ? ST_MAP_LO : ST_DIV_GO;
        end
      end
      ST_MAP_LO:  state_d = ST_MAP_HI;
      ST_MAP_HI:  state_d = ST_MAP_ADD;
      ST_MAP_ADD: state_d = (k_q == 2'd1) ? ST_DEPTH : ST_MAP_LO;
      ST_DEPTH:   state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          stage_q <= 1'b0;
          row_q   <= '0;
          col_q   <= '0;
          k_q     <= '0;
        end
        ST_ACCUM: begin
          col_q <= col_q + 1'b1;
          if (col_q == 2'd3) begin
            row_q <= row_q + 1'b1;
            if (row_q == 2'd3) begin
              stage_q <= 1'b1;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
          end
        end
        ST_MAP_ADD: k_q <= k_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        src_q[0] <= VW'(item_i.data.point_x);
        src_q[1] <= VW'(item_i.data.point_y);
        src_q[2] <= VW'(item_i.data.point_z);
        src_q[3] <= ONE_V;
        acc_q    <= '0;
      end
      ST_MUL_HI: p_q <= prod;
      ST_ACCUM: begin
        if (col_q == 2'd3) begin
          acc_q        <= '0;
          dst_q[row_q] <= row_sat;
          if (!stage_q && (row_q == 2'd3)) begin
            src_q[0] <= VW'(dst_q[0]);
            src_q[1] <= VW'(dst_q[1]);
            src_q[2] <= VW'(dst_q[2]);
            src_q[3] <= VW'(row_sat);
          end
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_CHECK: begin
        win_q[0] <= '0;
        win_q[1] <= '0;
        win_q[2] <= '0;
        ok_q     <= 1'b0;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          ndc_q[k_q] <= div_quot;
        end
      end
      ST_MAP_HI:  p_q <= prod;
      ST_MAP_ADD: win_q[k_q] <= map_res;
      ST_DEPTH: begin
        win_q[2] <= depth_res;
        ok_q     <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: holds the result until the receiver takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_q.window_x     <= win_q[0];
      out_q.window_y     <= win_q[1];
      out_q.window_z     <= win_q[2];
      out_q.projected_ok <= ok_q;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

@@ sim/vpw_checker.sv @@
// Checker that predicts projected window coordinates and compares result beats.
module vpw_checker import vpw_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vpw_cfg_if.sink      cfg_mon,
  vpw_in_if.sink       item_mon,
  vpw_out_if.sink      result_mon,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  localparam longint TermLim = 64'sd1 <<< 60;
  localparam longint QuoLim  = 64'sd1 <<< 50;
  localparam longint MapLim  = 64'sd1 <<< 47;
  localparam longint One     = 64'sd1 <<< FRAC_BITS;

  longint      coeffs [32];
  logic [15:0] vp_left, vp_bottom, vp_width, vp_height;
  out_item_t   window_q [$];

  assign pending_o = window_q.size();

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Truncated Q-format product, magnitude limited to 2^60.
  function automatic longint term_product(longint a, longint b);
    logic [63:0] ua, ub, p, q, t;
    ua = abs64(a);
    ub = abs64(b);
    p  = ua * ub[31:0];
    q  = ua * (ub >> 32);
    if (q >= (64'd1 << (28 + FRAC_BITS))) t = TermLim;
    else t = (q << (32 - FRAC_BITS)) + (p >> FRAC_BITS);
    if (t > TermLim) t = TermLim;
    return ((a < 0) != (b < 0)) ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint frac_quotient(longint n, longint d);
    logic [63:0] un, ud, q, r;
    un = abs64(n);
    ud = abs64(d);
    q  = un / ud;
    r  = un % ud;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (q >= QuoLim) begin
        q = QuoLim;
      end else begin
        q = q << 1;
        r = r << 1;
        if (r >= ud) begin
          r = r - ud;
          q[0] = 1'b1;
        end
      end
    end
    if (q > QuoLim) q = QuoLim;
    return sat_to(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q), WORD_BITS);
  endfunction

  function automatic longint to_viewport(longint ndc, longint origin, longint size);
    longint v;
    longint m;
    v = One + ndc;
    if (v > MapLim) v = MapLim;
    if (v < -MapLim) v = -MapLim;
    m = (abs64(v) * size) >>> 1;
    return sat_to((origin <<< FRAC_BITS) + (v < 0 ? -m : m), 32);
  endfunction

  function automatic out_item_t project_point(in_item_t it);
    longint    src [4];
    longint    eye [4];
    longint    clip [4];
    longint    acc;
    longint    depth;
    out_item_t r;
    src[0] = longint'(it.point_x);
    src[1] = longint'(it.point_y);
    src[2] = longint'(it.point_z);
    src[3] = One;
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += term_product(coeffs[4*c+row], src[c]);
      eye[row] = sat_to(acc, WORD_BITS);
    end
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += term_product(coeffs[16+4*c+row], eye[c]);
      clip[row] = sat_to(acc, WORD_BITS);
    end
    r = '0;
    if (clip[3] == 0) return r;
    depth = One + frac_quotient(clip[2], clip[3]);
    depth = depth < 0 ? -(abs64(depth) >>> 1) : (depth >>> 1);
    r.window_x = 32'(to_viewport(frac_quotient(clip[0], clip[3]), longint'(vp_left),
                                 longint'(vp_width)));
    r.window_y = 32'(to_viewport(frac_quotient(clip[1], clip[3]), longint'(vp_bottom),
                                 longint'(vp_height)));
    r.window_z = 32'(sat_to(depth, 32));
    r.projected_ok = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    int unsigned errs;
    if (!rst_ni) begin
      vp_left <= '0;
      vp_bottom <= '0;
      vp_width <= '0;
      vp_height <= '0;
      fail_count_o <= 0;
      foreach (coeffs[i]) coeffs[i] = 0;
    end else begin
      errs = 0;
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          REG_VP_LEFT:   vp_left <= cfg_mon.data.value;
          REG_VP_BOTTOM: vp_bottom <= cfg_mon.data.value;
          REG_VP_WIDTH:  vp_width <= cfg_mon.data.value;
          REG_VP_HEIGHT: vp_height <= cfg_mon.data.value;
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.data.operation == OP_LOAD)
          coeffs[item_mon.data.coeff_index] = longint'(item_mon.data.coeff_value);
        else window_q = {window_q, project_point(item_mon.data)};
      end
      if (result_mon.valid && result_mon.ready) begin
        if (window_q.size() == 0) begin
          $error("result beat with no expectation pending");
          errs++;
        end else begin
          want = window_q.pop_front();
          if (result_mon.data.window_x !== want.window_x) begin
            $error("window_x: expected %0d, got %0d", want.window_x,
                   result_mon.data.window_x);
            errs++;
          end
          if (result_mon.data.window_y !== want.window_y) begin
            $error("window_y: expected %0d, got %0d", want.window_y,
                   result_mon.data.window_y);
            errs++;
          end
          if (result_mon.data.window_z !== want.window_z) begin
            $error("window_z: expected %0d, got %0d", want.window_z,
                   result_mon.data.window_z);
            errs++;
          end
          if (result_mon.data.projected_ok !== want.projected_ok) begin
            $error("projected_ok: expected %0b, got %0b", want.projected_ok,
                   result_mon.data.projected_ok);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives the projection block and reports the verdict.
module tb_top;
  import vpw_pkg::*;

  localparam int InW = $bits(in_item_t);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int          sink_gap;

  vpw_cfg_if cfg_bus ();
  vpw_in_if  item_bus ();
  vpw_out_if result_bus ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vertex_project_to_window i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus.sink),
    .item_i  (item_bus.sink),
    .result_o(result_bus.source)
  );

  vpw_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon     (cfg_bus.sink),
    .item_mon    (item_bus.sink),
    .result_mon  (result_bus.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Mostly short gaps, now and then a long one, and zero often enough to
  // give back-to-back stretches.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Sink side: ready toggles after random gaps, set once per falling edge.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_gap > 0) begin
        result_bus.ready <= 1'b0;
        sink_gap--;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap = gap_len();
      end
    end
  end

  // One beat on the item channel, with a random gap before it. Valid stays
  // high across back-to-back beats; each beat is held until accepted.
  task automatic send_item(in_item_t it);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      item_bus.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    item_bus.data <= it;
    item_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!item_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic load_coeff(int idx, logic [31:0] value);
    in_item_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_LOAD;
    it.coeff_index = IDX_W'(idx);
    it.coeff_value = value;
    send_item(it);
  endtask

  task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_PROJECT;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    send_item(it);
  endtask

  // Let every pending result drain, then allow the tail of a load beat.
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [VP_W-1:0] value);
    cfg_bus.data <= '{index: idx, value: value};
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_viewport(logic [15:0] l, logic [15:0] b, logic [15:0] w,
                              logic [15:0] h);
    write_reg(REG_VP_LEFT, l);
    write_reg(REG_VP_BOTTOM, b);
    write_reg(REG_VP_WIDTH, w);
    write_reg(REG_VP_HEIGHT, h);
  endtask

  // Coefficients are mostly moderate Q16.16 values so that w stays away from
  // saturation; a share are full-range to exercise the limits.
  function automatic logic [31:0] rand_coeff();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
    if (pick < 8) return $urandom;
    return pick == 8 ? 32'h0001_0000 : 32'h0;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh007F_FFFF;
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 32; i++)
      load_coeff(i, (i % 16) % 5 == 0 ? 32'h0001_0000 : 32'h0);
  endtask

  initial begin
    int items;
    item_bus.valid = 1'b0;
    item_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: identity matrices, then a zero w row, then extremes.
    set_viewport(16'd0, 16'd0, 16'd640, 16'd480);
    load_identity();
    project(32'h0, 32'h0, 32'h0);
    project(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    project(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    load_coeff(31, 32'h0);
    project(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    load_coeff(31, 32'h0000_0001);
    project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_coeff(0, 32'h7FFF_FFFF);
    load_coeff(21, 32'h8000_0000);
    project(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    wait_idle();
    set_viewport(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    project(32'h0001_0000, 32'hFFFF_0000, 32'h0);
    project(32'h8000_0000, 32'h7FFF_FFFF, 32'h1);

    // Random phases, each with its own viewport and a fresh matrix set.
    items = 0;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: set_viewport(16'd0, 16'd0, 16'd0, 16'd0);
        1: set_viewport(16'hFFFF, 16'd0, 16'hFFFF, 16'd1);
        default: set_viewport(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
      endcase
      for (int i = 0; i < 32; i++) load_coeff(i, rand_coeff());
      items += 32;
      while (items < (phase + 1) * 200) begin
        if ($urandom_range(0, 4) == 0) load_coeff($urandom_range(0, 31), rand_coeff());
        else project(rand_coord(), rand_coord(), rand_coord());
        items++;
      end
    end

    wait_idle();
    repeat (400) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // About 1050 beats, with the longest gaps on both sides, come to about 12 million
  // time units at worst; this leaves ample margin.
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/vpw_pkg.sv
rtl/vpw_if.sv
rtl/vpw_coeff_mem.sv
rtl/vpw_mul.sv
rtl/vpw_divider.sv
rtl/vertex_project_to_window.sv
sim/vpw_checker.sv
sim/tb_top.sv
